// ===== rtl/core/quadratic_congruential_generator_macros.svh =====
// ---------------------------------------------------------------------------
// Quadratic congruential generator assertion macros
// Shared concurrent assertion forms for the generator core.
// ---------------------------------------------------------------------------
`ifndef QUADRATIC_CONGRUENTIAL_GENERATOR_MACROS_SVH
`define QUADRATIC_CONGRUENTIAL_GENERATOR_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset.
`define QCG_ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define QCG_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");

`else

`define QCG_ASSERT_IMPLIES(label, clk, rst_n, cond, prop)
`define QCG_ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

// ===== rtl/core/qcg_pkg.sv =====
// ---------------------------------------------------------------------------
// Quadratic congruential generator package
// Widths, reset values and register indexes of the generator.
// ---------------------------------------------------------------------------
package qcg_pkg;

    // Default widths.
    localparam int VALUE_WIDTH_DEF   = 31;
    localparam int FRACTION_BITS_DEF = 16;

    // Configuration register index width and indexes.
    localparam int CFG_INDEX_WIDTH = 3;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SQUARE    = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_LINEAR    = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_INCREMENT = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MODULUS   = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SEED      = 3'd4;

    // Register values after reset.
    localparam int RESET_SQUARE    = 3889;
    localparam int RESET_LINEAR    = 1777;
    localparam int RESET_INCREMENT = 7351;
    localparam int RESET_MODULUS   = 9973;
    localparam int RESET_SEED      = 1;

endpackage

// ===== rtl/core/quadratic_congruential_generator.sv =====
// A draw word steps the sequencer through the multiplication phases, the modular adds,
// the fraction division and the output register; with modulus zero the value becomes 0.
// No new draw word is taken until the last result is parked in the output register;
// the work runs on one shared modular shift-add unit, and a zero draw word starts no work.
// A result left waiting in the output register holds the core until out_ready.
// Reset (rst_n, async, active low) loads register defaults and sets the generator state x to 1.
// ---------------------------------------------------------------------------
// Quadratic congruential generator
// Advances x to (d*x*x + a*x + c) mod m per draw word and returns the new
// value and its truncated fraction x/m, using one iterative modular unit.
// ---------------------------------------------------------------------------
`include "quadratic_congruential_generator_macros.svh"

module quadratic_congruential_generator #(
    parameter int VALUE_WIDTH   = qcg_pkg::VALUE_WIDTH_DEF,
    parameter int FRACTION_BITS = qcg_pkg::FRACTION_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                draw,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [VALUE_WIDTH-1:0]              value,
    output logic [FRACTION_BITS-1:0]            fraction,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [qcg_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [VALUE_WIDTH-1:0]              cfg_data
);

    localparam int W  = VALUE_WIDTH;
    localparam int F  = FRACTION_BITS;
    localparam int QW = (W > F) ? W : F;
    localparam int CW = $clog2(QW);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_ADD  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    // Multiplication phases.
    localparam logic [2:0] OP_XRED = 3'd0;  // x mod m
    localparam logic [2:0] OP_LIN  = 3'd1;  // a*x mod m
    localparam logic [2:0] OP_SQA  = 3'd2;  // d*x mod m
    localparam logic [2:0] OP_SQB  = 3'd3;  // d*x*x mod m
    localparam logic [2:0] OP_INC  = 3'd4;  // c mod m

    // Configuration registers and generator state.
    logic [W-1:0] square_reg, linear_reg, increment_reg, modulus_reg;
    logic [W-1:0] x_reg, x_next;

    // Sequencer and datapath registers.
    logic [2:0]    state_reg, state_next;
    logic [2:0]    op_reg, op_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  acc_reg, acc_next;
    logic [W-1:0]  p_reg, p_next;
    logic [QW-1:0] q_reg, q_next;
    logic [W-1:0]  xr_reg, xr_next;
    logic [W-1:0]  t_reg, t_next;

    // Output registers.
    logic          out_valid_reg, out_valid_next;
    logic [W-1:0]  value_reg, value_next;
    logic [F-1:0]  fraction_reg, fraction_next;

    // Shared modular unit signals.
    logic [W:0]    dbl;
    logic          ge1;
    logic [W-1:0]  r1;
    logic [W-1:0]  base;
    logic [W-1:0]  add_in;
    logic [W:0]    s2;
    logic          ge2;
    logic [W-1:0]  r2;

    logic in_fire, cfg_fire, out_fire;

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign out_fire  = out_valid_reg && out_ready;

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign fraction  = fraction_reg;

    // Shared unit: doubling with one conditional subtract, then a modular add.
    always_comb
    begin
        dbl    = {acc_reg, 1'b0};
        ge1    = (dbl >= {1'b0, modulus_reg});
        r1     = ge1 ? W'(dbl - {1'b0, modulus_reg}) : dbl[W-1:0];
        base   = (state_reg == ST_ADD) ? acc_reg : r1;
        if (state_reg == ST_ADD)
        begin
            add_in = t_reg;
        end
        else
        begin
            add_in = q_reg[W-1] ? p_reg : '0;
        end
        s2     = {1'b0, base} + {1'b0, add_in};
        ge2    = (s2 >= {1'b0, modulus_reg});
        r2     = ge2 ? W'(s2 - {1'b0, modulus_reg}) : s2[W-1:0];
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        cnt_next       = cnt_reg;
        acc_next       = acc_reg;
        p_next         = p_reg;
        q_next         = q_reg;
        xr_next        = xr_reg;
        t_next         = t_reg;
        x_next         = x_reg;
        out_valid_next = out_valid_reg;
        value_next     = value_reg;
        fraction_next  = fraction_reg;

        if (out_fire)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cfg_fire && (cfg_index == qcg_pkg::REG_SEED))
                begin
                    x_next = cfg_data;
                end
                if (in_fire && draw)
                begin
                    if (modulus_reg == '0)
                    begin
                        t_next     = '0;
                        q_next     = '0;
                        x_next     = '0;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        p_next     = W'(1);
                        q_next     = QW'(x_reg);
                        acc_next   = '0;
                        cnt_next   = '0;
                        op_next    = OP_XRED;
                        state_next = ST_MUL;
                    end
                end
            end

            ST_MUL:
            begin
                acc_next = r2;
                q_next   = q_reg << 1;
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(W - 1))
                begin
                    cnt_next = '0;
                    acc_next = '0;
                    unique case (op_reg)
                        OP_XRED:
                        begin
                            xr_next = r2;
                            p_next  = r2;
                            q_next  = QW'(linear_reg);
                            op_next = OP_LIN;
                        end
                        OP_LIN:
                        begin
                            t_next  = r2;
                            p_next  = xr_reg;
                            q_next  = QW'(square_reg);
                            op_next = OP_SQA;
                        end
                        OP_SQA:
                        begin
                            q_next  = QW'(r2);
                            op_next = OP_SQB;
                        end
                        OP_SQB, OP_INC:
                        begin
                            acc_next   = r2;
                            state_next = ST_ADD;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_ADD:
            begin
                t_next   = r2;
                acc_next = r2;
                cnt_next = '0;
                if (op_reg == OP_SQB)
                begin
                    p_next     = W'(1);
                    q_next     = QW'(increment_reg);
                    acc_next   = '0;
                    op_next    = OP_INC;
                    state_next = ST_MUL;
                end
                else
                begin
                    x_next     = r2;
                    q_next     = '0;
                    state_next = ST_DIV;
                end
            end

            // Restoring division: one quotient bit of value/m per cycle.
            ST_DIV:
            begin
                acc_next = r1;
                q_next   = {q_reg[QW-2:0], ge1};
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(F - 1))
                begin
                    state_next = ST_FIN;
                end
            end

            // Park the result in the output register once it is free.
            ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    value_next     = t_reg;
                    fraction_next  = q_reg[F-1:0];
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Configuration registers. A seed write only loads the kept value,
    // which the sequencer takes care of.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            square_reg    <= W'(qcg_pkg::RESET_SQUARE);
            linear_reg    <= W'(qcg_pkg::RESET_LINEAR);
            increment_reg <= W'(qcg_pkg::RESET_INCREMENT);
            modulus_reg   <= W'(qcg_pkg::RESET_MODULUS);
        end
        else if (cfg_fire)
        begin
            unique case (cfg_index)
                qcg_pkg::REG_SQUARE:    square_reg    <= cfg_data;
                qcg_pkg::REG_LINEAR:    linear_reg    <= cfg_data;
                qcg_pkg::REG_INCREMENT: increment_reg <= cfg_data;
                qcg_pkg::REG_MODULUS:   modulus_reg   <= cfg_data;
                default:                ;
            endcase
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_XRED;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            x_reg         <= W'(qcg_pkg::RESET_SEED);
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            x_reg         <= x_next;
        end
    end

    // Datapath and payload registers.
    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        p_reg        <= p_next;
        q_reg        <= q_next;
        xr_reg       <= xr_next;
        t_reg        <= t_next;
        value_reg    <= value_next;
        fraction_reg <= fraction_next;
    end

    // The running residue stays below the modulus while the unit is busy.
    `QCG_ASSERT_IMPLIES(a_acc_below_modulus, clk, rst_n, ((state_reg == ST_MUL) || (state_reg == ST_ADD) || (state_reg == ST_DIV)), (acc_reg < modulus_reg))

    // A draw word always starts work.
    `QCG_ASSERT_NEXT(a_draw_leaves_idle, clk, rst_n, (in_valid && in_ready && draw), (state_reg != ST_IDLE))

    // The step counter never passes the operand width during multiplication.
    `QCG_ASSERT_IMPLIES(a_mul_count_bound, clk, rst_n, (state_reg == ST_MUL), (cnt_reg <= CW'(W - 1)))

endmodule
